// ===== design/smoa_pkg.sv =====
// Shared constants, the sequencer state type and the histogram control bundle
// for the sliding median outlier alert block. Depends on nothing.
package smoa_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned WINDOW_DEPTH_DEF = 1024;
  localparam int unsigned VALUE_LEVELS_DEF = 256;

  // Fixed field widths of the request and result channels.
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned DBL_W    = 9;
  localparam int unsigned TOTAL_W  = 32;

  // Configuration port geometry.
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  // Register index of window_size (the index bit of paddr).
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL_WR,
    S_SCAN_INIT,
    S_SCAN_DBL,
    S_LEAVE_RD,
    S_LEAVE_WR,
    S_ENTER_WR,
    S_CHECK,
    S_SCAN_UP,
    S_SCAN_DN,
    S_DONE
  } state_t;

  // Control strobes from the sequencer to the histogram memory.
  typedef struct packed {
    logic clear;
    logic wr_en;
    logic rd_en;
  } hist_ctl_t;

endpackage

// ===== design/smoa_hist.sv =====
// Histogram count memory: one synchronous RAM with a registered read port,
// per-bin valid bits that clear all bins together, and same-cycle write forwarding.
// Depends on smoa_pkg.
module smoa_hist #(
  parameter int unsigned LEVELS = smoa_pkg::VALUE_LEVELS_DEF,
  parameter int unsigned CNT_W  = 11,
  localparam int unsigned AW    = $clog2(LEVELS)
) (
  input  logic                clk,
  input  logic                rst,
  input  smoa_pkg::hist_ctl_t ctl,
  input  logic [AW-1:0]       rd_addr,
  input  logic [AW-1:0]       wr_addr,
  input  logic [CNT_W-1:0]    wr_data,
  output logic [CNT_W-1:0]    rd_data
);

  logic [CNT_W-1:0] mem [LEVELS];
  logic [LEVELS-1:0] valid;
  logic [CNT_W-1:0] q;
  logic [CNT_W-1:0] fwd_data;
  logic             q_valid;
  logic             fwd_hit;

  // Array write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; a write to the same bin in the same cycle is
  // captured so that the read returns the new count.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      q        <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // Valid bits: a bin never written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      q_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (ctl.clear) begin
        valid <= '0;
      end else if (ctl.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        q_valid <= valid[rd_addr];
        fwd_hit <= ctl.wr_en && (wr_addr == rd_addr);
      end
    end
  end

  assign rd_data = fwd_hit ? fwd_data : (q_valid ? q : '0);

endmodule

// ===== design/sliding_median_outlier_alert.sv =====
// Sliding-window median outlier alert. Each sample request is stored in a
// ring of the last window_size samples and counted in a histogram memory
// with one bin per value. While the window fills, a request only stores and
// counts its sample; the request that completes the window adds a median
// scan up from value zero. With a full window a request compares, replaces
// the oldest sample, updates the leaving and entering bins and checks the
// balance; every move of the median adds a search for the next occupied bin
// and one more balance check, and an even window with the median exactly
// in the middle first adds a search for the next lower occupied bin. This
// order follows from the single read-modify-write path into the histogram
// memory and its one-bin-per-cycle scan. No clearing pass is needed after
// reset or at end of stream: histogram bins carry valid bits. Results wait
// in an output register, so a result may stay untaken while the next
// request is accepted. Depends on smoa_pkg and smoa_hist.
module sliding_median_outlier_alert #(
  parameter int unsigned WINDOW_DEPTH = smoa_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned VALUE_LEVELS = smoa_pkg::VALUE_LEVELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [smoa_pkg::APB_AW-1:0]    paddr,
  input  logic [smoa_pkg::APB_DW-1:0]    pwdata,
  output logic [smoa_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [smoa_pkg::SAMPLE_W-1:0]  sample,
  input  logic                           last_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           alert,
  output logic                           window_full,
  output logic [smoa_pkg::DBL_W-1:0]     doubled_median,
  output logic [smoa_pkg::TOTAL_W-1:0]   alert_total,
  output logic                           final_res
);

  localparam int unsigned BW  = $clog2(VALUE_LEVELS);
  localparam int unsigned CW  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned RAW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [BW-1:0] TOP_BIN = BW'(VALUE_LEVELS - 1);
  localparam logic [smoa_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

  smoa_pkg::state_t state, state_next;

  // Stream state.
  logic [CW-1:0]  window_size;
  logic [RAW-1:0] ring_pointer, ring_pointer_next;
  logic [CW-1:0]  fill_level, fill_level_next;
  logic [BW-1:0]  median_value, median_value_next;
  logic [CW-1:0]  below_median_count, below_median_count_next;
  logic [smoa_pkg::TOTAL_W-1:0] alert_counter, alert_counter_next;

  // Working registers of the request in flight.
  logic [BW-1:0]  smp, smp_next;
  logic           item_last, item_last_next;
  logic           item_alert, item_alert_next;
  logic           item_full, item_full_next;
  logic [BW:0]    dbl, dbl_next;
  logic [CW-1:0]  med_cnt, med_cnt_next;
  logic           cnt_live, cnt_live_next;
  logic [CW-1:0]  acc, acc_next;
  logic [BW-1:0]  scan_addr, scan_addr_next;
  logic           scan_pend, scan_pend_next;
  logic [BW-1:0]  pend_addr, pend_addr_next;

  // Output register next values.
  logic           out_valid_next;
  logic           load_out;

  // Ring memory.
  logic [BW-1:0]  ring [WINDOW_DEPTH];
  logic [BW-1:0]  ring_q;
  logic           ring_rd_en;
  logic           ring_we;
  logic [BW-1:0]  ring_wdata;

  // Histogram memory interface.
  smoa_pkg::hist_ctl_t hist_ctl;
  logic [BW-1:0]  hist_rd_addr;
  logic [BW-1:0]  hist_wr_addr;
  logic [CW-1:0]  hist_wr_data;
  logic [CW-1:0]  hist_rd_data;

  // Derived values.
  logic           cfg_we;
  logic [31:0]    cfg_val;
  logic           clear_stream;
  logic [BW-1:0]  s_in;
  logic [CW-1:0]  mid_pos;
  logic [CW-1:0]  half_size;
  logic           d_even;
  logic           ptr_wrap;
  logic [RAW-1:0] ring_pointer_step;
  logic [CW-1:0]  cur_cnt;
  logic           up_need;
  logic           down_need;
  logic [CW:0]    init_sum;
  logic [BW-1:0]  scan_up_addr;
  logic [BW-1:0]  scan_dn_addr;

  // Configuration port: one register; the user must write it only while idle, the block does not enforce this.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready &&
                   (paddr[smoa_pkg::APB_AW-1] == smoa_pkg::REG_WINDOW_SIZE);
  assign cfg_val = 32'(pwdata[smoa_pkg::CFG_W-1:0]);
  assign prdata  = smoa_pkg::APB_DW'(window_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= CW'(1);
    end else if (cfg_we) begin
      if (cfg_val == 32'd0) begin
        window_size <= CW'(1);
      end else if (cfg_val > 32'(WINDOW_DEPTH)) begin
        window_size <= CW'(WINDOW_DEPTH);
      end else begin
        window_size <= CW'(cfg_val);
      end
    end
  end

  // Sample clipped to the histogram range.
  always_comb begin
    if (32'(sample) > 32'(VALUE_LEVELS - 1)) begin
      s_in = TOP_BIN;
    end else begin
      s_in = BW'(sample);
    end
  end

  // Window geometry and ring pointer advance.
  assign half_size         = window_size >> 1;
  assign mid_pos           = half_size + CW'(1);
  assign d_even            = ~window_size[0];
  assign ptr_wrap          = (CW'(ring_pointer) + CW'(1)) == window_size;
  assign ring_pointer_step = ptr_wrap ? '0 : ring_pointer + RAW'(1);

  // Median balance test; the bin count comes straight from memory right
  // after the insert, and from a register after a scan.
  assign cur_cnt   = cnt_live ? hist_rd_data : med_cnt;
  assign up_need   = ({1'b0, below_median_count} + {1'b0, cur_cnt}) < {1'b0, mid_pos};
  assign down_need = below_median_count >= mid_pos;
  assign init_sum  = {1'b0, acc} + {1'b0, hist_rd_data};

  // Scan address steps stop at the ends of the value range.
  assign scan_up_addr = (scan_addr == TOP_BIN) ? scan_addr : scan_addr + BW'(1);
  assign scan_dn_addr = (scan_addr == '0) ? scan_addr : scan_addr - BW'(1);

  assign in_ready = (state == smoa_pkg::S_IDLE);
  assign load_out = (state == smoa_pkg::S_DONE) && (!out_valid || out_ready);
  assign clear_stream = cfg_we || (load_out && item_last);

  // Sequencer: next state, memory strobes and working register updates.
  always_comb begin
    state_next              = state;
    ring_pointer_next       = ring_pointer;
    fill_level_next         = fill_level;
    median_value_next       = median_value;
    below_median_count_next = below_median_count;
    alert_counter_next      = alert_counter;
    smp_next                = smp;
    item_last_next          = item_last;
    item_alert_next         = item_alert;
    item_full_next          = item_full;
    dbl_next                = dbl;
    med_cnt_next            = med_cnt;
    cnt_live_next           = cnt_live;
    acc_next                = acc;
    scan_addr_next          = scan_addr;
    scan_pend_next          = scan_pend;
    pend_addr_next          = pend_addr;
    ring_rd_en              = 1'b0;
    ring_we                 = 1'b0;
    ring_wdata              = smp;
    hist_ctl                = '0;
    hist_rd_addr            = smp;
    hist_wr_addr            = smp;
    hist_wr_data            = hist_rd_data + CW'(1);

    case (state)
      // Take a request; a filling window only stores, a full one first
      // settles the threshold of the window before the shift.
      smoa_pkg::S_IDLE: begin
        if (in_valid) begin
          smp_next        = s_in;
          item_last_next  = last_sample;
          item_alert_next = 1'b0;
          if (fill_level < window_size) begin
            item_full_next  = 1'b0;
            dbl_next        = '0;
            ring_we         = 1'b1;
            ring_wdata      = s_in;
            hist_ctl.rd_en  = 1'b1;
            hist_rd_addr    = s_in;
            state_next      = smoa_pkg::S_FILL_WR;
          end else begin
            item_full_next = 1'b1;
            ring_rd_en     = 1'b1;
            if (d_even && (below_median_count == half_size) && (median_value != '0)) begin
              scan_addr_next = median_value - BW'(1);
              scan_pend_next = 1'b0;
              state_next     = smoa_pkg::S_SCAN_DBL;
            end else begin
              dbl_next   = {median_value, 1'b0};
              state_next = smoa_pkg::S_LEAVE_RD;
            end
          end
        end
      end

      // Count the new sample while the window fills.
      smoa_pkg::S_FILL_WR: begin
        hist_ctl.wr_en    = 1'b1;
        fill_level_next   = fill_level + CW'(1);
        ring_pointer_next = ring_pointer_step;
        if ((fill_level + CW'(1)) == window_size) begin
          scan_addr_next = '0;
          scan_pend_next = 1'b0;
          acc_next       = '0;
          state_next     = smoa_pkg::S_SCAN_INIT;
        end else begin
          state_next = smoa_pkg::S_DONE;
        end
      end

      // First median: walk the bins from value zero, accumulating counts.
      smoa_pkg::S_SCAN_INIT: begin
        hist_ctl.rd_en = 1'b1;
        hist_rd_addr   = scan_addr;
        scan_addr_next = scan_up_addr;
        scan_pend_next = 1'b1;
        pend_addr_next = scan_addr;
        if (scan_pend) begin
          if (init_sum >= {1'b0, mid_pos}) begin
            median_value_next       = pend_addr;
            below_median_count_next = acc;
            state_next              = smoa_pkg::S_DONE;
          end else begin
            acc_next = acc + hist_rd_data;
            if (pend_addr == TOP_BIN) begin
              median_value_next       = '0;
              below_median_count_next = '0;
              state_next              = smoa_pkg::S_DONE;
            end
          end
        end
      end

      // Even window with the median in the middle: add the next lower value.
      smoa_pkg::S_SCAN_DBL: begin
        hist_ctl.rd_en = 1'b1;
        hist_rd_addr   = scan_addr;
        scan_addr_next = scan_dn_addr;
        scan_pend_next = 1'b1;
        pend_addr_next = scan_addr;
        if (scan_pend) begin
          if (hist_rd_data != '0) begin
            dbl_next   = {1'b0, median_value} + {1'b0, pend_addr};
            state_next = smoa_pkg::S_LEAVE_RD;
          end else if (pend_addr == '0) begin
            dbl_next   = {median_value, 1'b0};
            state_next = smoa_pkg::S_LEAVE_RD;
          end
        end
      end

      // Compare, count the alert, replace the oldest sample in the ring and
      // fetch the count of its bin.
      smoa_pkg::S_LEAVE_RD: begin
        ring_we           = 1'b1;
        ring_wdata        = smp;
        ring_pointer_next = ring_pointer_step;
        hist_ctl.rd_en    = 1'b1;
        hist_rd_addr      = ring_q;
        if ({1'b0, smp} >= dbl) begin
          item_alert_next = 1'b1;
          if (alert_counter != TOTAL_MAX) begin
            alert_counter_next = alert_counter + 1'b1;
          end
        end
        if ((ring_q < median_value) && (below_median_count != '0)) begin
          below_median_count_next = below_median_count - CW'(1);
        end
        state_next = smoa_pkg::S_LEAVE_WR;
      end

      // Decrement the leaving bin and fetch the entering bin.
      smoa_pkg::S_LEAVE_WR: begin
        hist_wr_addr   = ring_q;
        hist_wr_data   = hist_rd_data - CW'(1);
        hist_ctl.wr_en = (hist_rd_data != '0);
        hist_ctl.rd_en = 1'b1;
        hist_rd_addr   = smp;
        state_next     = smoa_pkg::S_ENTER_WR;
      end

      // Increment the entering bin and fetch the median bin.
      smoa_pkg::S_ENTER_WR: begin
        hist_ctl.wr_en = 1'b1;
        hist_ctl.rd_en = 1'b1;
        hist_rd_addr   = median_value;
        if (smp < median_value) begin
          below_median_count_next = below_median_count + CW'(1);
        end
        cnt_live_next = 1'b1;
        state_next    = smoa_pkg::S_CHECK;
      end

      // Decide whether the median must move up or down.
      smoa_pkg::S_CHECK: begin
        cnt_live_next  = 1'b0;
        med_cnt_next   = cur_cnt;
        scan_pend_next = 1'b0;
        if (up_need) begin
          if (median_value == TOP_BIN) begin
            state_next = smoa_pkg::S_DONE;
          end else begin
            scan_addr_next = median_value + BW'(1);
            state_next     = smoa_pkg::S_SCAN_UP;
          end
        end else if (down_need) begin
          if (median_value == '0) begin
            state_next = smoa_pkg::S_DONE;
          end else begin
            scan_addr_next = median_value - BW'(1);
            state_next     = smoa_pkg::S_SCAN_DN;
          end
        end else begin
          state_next = smoa_pkg::S_DONE;
        end
      end

      // Move the median to the next occupied bin above.
      smoa_pkg::S_SCAN_UP: begin
        hist_ctl.rd_en = 1'b1;
        hist_rd_addr   = scan_addr;
        scan_addr_next = scan_up_addr;
        scan_pend_next = 1'b1;
        pend_addr_next = scan_addr;
        if (scan_pend) begin
          if (hist_rd_data != '0) begin
            below_median_count_next = below_median_count + med_cnt;
            median_value_next       = pend_addr;
            med_cnt_next            = hist_rd_data;
            state_next              = smoa_pkg::S_CHECK;
          end else if (pend_addr == TOP_BIN) begin
            state_next = smoa_pkg::S_DONE;
          end
        end
      end

      // Move the median to the next occupied bin below.
      smoa_pkg::S_SCAN_DN: begin
        hist_ctl.rd_en = 1'b1;
        hist_rd_addr   = scan_addr;
        scan_addr_next = scan_dn_addr;
        scan_pend_next = 1'b1;
        pend_addr_next = scan_addr;
        if (scan_pend) begin
          if (hist_rd_data != '0) begin
            median_value_next = pend_addr;
            med_cnt_next      = hist_rd_data;
            if (below_median_count >= hist_rd_data) begin
              below_median_count_next = below_median_count - hist_rd_data;
            end else begin
              below_median_count_next = '0;
            end
            state_next = smoa_pkg::S_CHECK;
          end else if (pend_addr == '0) begin
            state_next = smoa_pkg::S_DONE;
          end
        end
      end

      // Hand the result to the output register once it is free.
      smoa_pkg::S_DONE: begin
        if (load_out) begin
          state_next = smoa_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = smoa_pkg::S_IDLE;
      end
    endcase

    // End of stream or a new window size: empty the window.
    if (clear_stream) begin
      ring_pointer_next       = '0;
      fill_level_next         = '0;
      median_value_next       = '0;
      below_median_count_next = '0;
      alert_counter_next      = '0;
      hist_ctl.clear          = 1'b1;
    end
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= smoa_pkg::S_IDLE;
      ring_pointer       <= '0;
      fill_level         <= '0;
      median_value       <= '0;
      below_median_count <= '0;
      alert_counter      <= '0;
      cnt_live           <= 1'b0;
      scan_pend          <= 1'b0;
    end else begin
      state              <= state_next;
      ring_pointer       <= ring_pointer_next;
      fill_level         <= fill_level_next;
      median_value       <= median_value_next;
      below_median_count <= below_median_count_next;
      alert_counter      <= alert_counter_next;
      cnt_live           <= cnt_live_next;
      scan_pend          <= scan_pend_next;
    end
  end

  // Working registers of the request in flight.
  always_ff @(posedge clk) begin
    smp        <= smp_next;
    item_last  <= item_last_next;
    item_alert <= item_alert_next;
    item_full  <= item_full_next;
    dbl        <= dbl_next;
    med_cnt    <= med_cnt_next;
    acc        <= acc_next;
    scan_addr  <= scan_addr_next;
    pend_addr  <= pend_addr_next;
  end

  // Ring memory with a registered read port.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_pointer] <= ring_wdata;
    end
    if (ring_rd_en) begin
      ring_q <= ring[ring_pointer];
    end
  end

  // Histogram memory.
  smoa_hist #(
    .LEVELS (VALUE_LEVELS),
    .CNT_W  (CW)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .ctl     (hist_ctl),
    .rd_addr (hist_rd_addr),
    .wr_addr (hist_wr_addr),
    .wr_data (hist_wr_data),
    .rd_data (hist_rd_data)
  );

  // Output register: holds a result until it is taken.
  always_comb begin
    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      alert          <= item_alert;
      window_full    <= item_full;
      doubled_median <= smoa_pkg::DBL_W'(dbl);
      alert_total    <= alert_counter;
      final_res      <= item_last;
    end
  end

endmodule

// ===== design/smoa_check.sv =====
// Port-level checker for the sliding median outlier alert block, with the
// bind that attaches it to the top level. Depends on smoa_pkg.
module smoa_check #(
  parameter int unsigned WINDOW_DEPTH = smoa_pkg::WINDOW_DEPTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [smoa_pkg::APB_AW-1:0]   paddr,
  input logic [smoa_pkg::APB_DW-1:0]   pwdata,
  input logic [smoa_pkg::APB_DW-1:0]   prdata,
  input logic                          pready,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          alert,
  input logic [smoa_pkg::DBL_W-1:0]    doubled_median,
  input logic [smoa_pkg::TOTAL_W-1:0]  alert_total
);

  // One request at a time: a new request closes the input until done.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another one is in flight");

  // A result only appears after a request has been worked on.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(alert) &&
      $stable(doubled_median) && $stable(alert_total))
    else $error("stalled result changed");

  // An in-range window size write reads back unchanged.
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready &&
      (paddr[smoa_pkg::APB_AW-1] == smoa_pkg::REG_WINDOW_SIZE) &&
      (pwdata[smoa_pkg::CFG_W-1:0] != '0) &&
      (32'(pwdata[smoa_pkg::CFG_W-1:0]) <= 32'(WINDOW_DEPTH))
    |=> prdata == smoa_pkg::APB_DW'($past(pwdata[smoa_pkg::CFG_W-1:0])))
    else $error("window size readback mismatch");

endmodule

bind sliding_median_outlier_alert smoa_check #(
  .WINDOW_DEPTH (WINDOW_DEPTH)
) u_smoa_check (.*);

// ===== tb/sliding_median_outlier_alert_test.sv =====
// Testbench for sliding_median_outlier_alert: sample requests and window size
// writes go in, and each result is checked against an in-bench median tracker.
// Depends on smoa_pkg and the sliding_median_outlier_alert RTL.
module sliding_median_outlier_alert_test;

  localparam int unsigned DEPTH        = smoa_pkg::WINDOW_DEPTH_DEF;
  localparam int unsigned LEVELS       = smoa_pkg::VALUE_LEVELS_DEF;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned SETTLE       = 16;
  localparam int unsigned SHOW_MAX     = 10;
  localparam logic [smoa_pkg::APB_AW-1:0] WINDOW_SIZE_ADDR =
    {smoa_pkg::REG_WINDOW_SIZE, 2'b00};

  typedef struct packed {
    logic                         alert;
    logic                         full;
    logic [smoa_pkg::DBL_W-1:0]   dbl;
    logic [smoa_pkg::TOTAL_W-1:0] total;
    logic                         fin;
  } alert_result_t;

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [smoa_pkg::APB_AW-1:0]   paddr;
  logic [smoa_pkg::APB_DW-1:0]   pwdata;
  logic [smoa_pkg::APB_DW-1:0]   prdata;
  logic                          pready;
  logic                          in_valid;
  logic                          in_ready;
  logic [smoa_pkg::SAMPLE_W-1:0] sample;
  logic                          last_sample;
  logic                          out_valid;
  logic                          out_ready;
  logic                          alert;
  logic                          window_full;
  logic [smoa_pkg::DBL_W-1:0]    doubled_median;
  logic [smoa_pkg::TOTAL_W-1:0]  alert_total;
  logic                          final_res;

  // Median tracker state.
  int unsigned                   bin_count [LEVELS];
  logic [smoa_pkg::SAMPLE_W-1:0] ring_val [DEPTH];
  int unsigned                   wr_ptr;
  int unsigned                   fill_cnt;
  int unsigned                   med_val;
  int unsigned                   below_cnt;
  logic [smoa_pkg::TOTAL_W-1:0]  alert_cnt;
  int unsigned                   win_len;

  alert_result_t pending_alerts [$];
  int unsigned   mismatches;
  int unsigned   cycle_count = 0;
  int unsigned   snd_idle_pct;
  int unsigned   rcv_idle_pct;

  sliding_median_outlier_alert i_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .last_sample    (last_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .alert          (alert),
    .window_full    (window_full),
    .doubled_median (doubled_median),
    .alert_total    (alert_total),
    .final_res      (final_res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Forget the current stream; the window length and ring contents survive.
  function automatic void clear_stream();
    for (int i = 0; i < LEVELS; i++) begin
      bin_count[i] = 0;
    end
    wr_ptr    = 0;
    fill_cnt  = 0;
    med_val   = 0;
    below_cnt = 0;
    alert_cnt = '0;
  endfunction

  function automatic int unsigned occupied_up(int unsigned v);
    for (int i = v + 1; i < LEVELS; i++) begin
      if (bin_count[i] != 0) return i;
    end
    return v;
  endfunction

  function automatic int unsigned occupied_down(int unsigned v);
    for (int i = int'(v) - 1; i >= 0; i--) begin
      if (bin_count[i] != 0) return i;
    end
    return v;
  endfunction

  // Walk the median to a neighboring occupied bin until the middle rank
  // falls inside the median bin again.
  function automatic void move_median(int unsigned mid_pos);
    int unsigned n;
    for (int guard = 0; guard < LEVELS; guard++) begin
      if (below_cnt + bin_count[med_val] < mid_pos) begin
        n = occupied_up(med_val);
        if (n == med_val) break;
        below_cnt += bin_count[med_val];
        med_val = n;
      end else if (below_cnt >= mid_pos) begin
        n = occupied_down(med_val);
        if (n == med_val) break;
        med_val = n;
        below_cnt = (below_cnt >= bin_count[n]) ? below_cnt - bin_count[n] : 0;
      end else begin
        break;
      end
    end
  endfunction

  // Advance the tracker by one sample and return the result it should give.
  function automatic alert_result_t track_sample(logic [smoa_pkg::SAMPLE_W-1:0] s,
                                                 logic fin);
    alert_result_t res;
    int unsigned   d;
    int unsigned   mid_pos;
    int unsigned   ptr;
    int unsigned   dbl;
    int unsigned   acc;
    int unsigned   leave;
    d       = win_len;
    mid_pos = d / 2 + 1;
    ptr     = wr_ptr % d;
    dbl     = 0;
    res     = '0;
    if (fill_cnt < d) begin
      // Still filling: store only, and fix the median once the window is full.
      ring_val[ptr] = s;
      bin_count[s]++;
      fill_cnt++;
      wr_ptr = (ptr + 1) % d;
      if (fill_cnt == d) begin
        acc       = 0;
        med_val   = 0;
        below_cnt = 0;
        for (int i = 0; i < LEVELS; i++) begin
          if (acc + bin_count[i] >= mid_pos) begin
            med_val   = i;
            below_cnt = acc;
            break;
          end
          acc += bin_count[i];
        end
      end
    end else begin
      // Compare against the window before this sample, then slide it.
      res.full = 1'b1;
      dbl = med_val * 2;
      if (d % 2 == 0 && below_cnt == d / 2) dbl = med_val + occupied_down(med_val);
      if (s >= dbl) begin
        res.alert = 1'b1;
        if (alert_cnt != '1) alert_cnt++;
      end
      leave = ring_val[ptr];
      if (bin_count[leave] != 0) bin_count[leave]--;
      if (leave < med_val && below_cnt != 0) below_cnt--;
      bin_count[s]++;
      if (s < med_val) below_cnt++;
      ring_val[ptr] = s;
      wr_ptr = (ptr + 1) % d;
      move_median(mid_pos);
    end
    res.dbl   = dbl[smoa_pkg::DBL_W-1:0];
    res.total = alert_cnt;
    res.fin   = fin;
    if (fin) clear_stream();
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (mismatches < SHOW_MAX) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
    mismatches++;
  endtask

  // Send one sample request, with a random gap in front of it.
  task automatic send_sample(input logic [smoa_pkg::SAMPLE_W-1:0] s, input logic fin);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid    <= 1'b1;
    sample      <= s;
    last_sample <= fin;
    pending_alerts.push_back(track_sample(s, fin));
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender until every result is back, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_alerts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write window_size while idle; the block saturates it and restarts the stream.
  task automatic set_window_size(input logic [smoa_pkg::APB_DW-1:0] value);
    int unsigned v;
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WINDOW_SIZE_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    v = value[smoa_pkg::CFG_W-1:0];
    if (v < 1) v = 1;
    if (v > DEPTH) v = DEPTH;
    win_len = v;
    clear_stream();
  endtask

  // A one-sample window: the median is simply the previous sample.
  task automatic test_single_window();
    set_window_size(32'd0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b1);
  endtask

  // Even window, so the threshold is the sum of the two middle values;
  // upper register bits are ignored.
  task automatic test_even_window();
    set_window_size(32'hFFFF_F802);
    send_sample(8'd10, 1'b0);
    send_sample(8'd20, 1'b0);
    send_sample(8'd30, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b1);
  endtask

  // Odd window of zeros: a zero median alerts on any sample.
  task automatic test_odd_window();
    set_window_size(32'd3);
    send_sample(8'd0, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd1, 1'b1);
  endtask

  // Deepest window, written exactly and by saturation; it never fills here.
  task automatic test_deepest_window();
    set_window_size(DEPTH);
    send_sample(8'd128, 1'b0);
    send_sample(8'd127, 1'b1);
    set_window_size(32'h0000_07FF);
    send_sample(8'd255, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd85, 1'b0);
    send_sample(8'd170, 1'b1);
  endtask

  // Random streams: mostly a full window followed by slides, with some
  // streams cut short or left open, and window sizes changed now and then.
  task automatic test_random_streams(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int unsigned mode;
    int unsigned base;
    int unsigned spread;
    int unsigned v;
    logic        close_stream;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(2) == 0) begin
        pick = $urandom_range(99);
        if (pick < 60) set_window_size($urandom_range(1, 8));
        else if (pick < 85) set_window_size($urandom_range(9, 32));
        else if (pick < 97) set_window_size($urandom_range(33, 100));
        else set_window_size($urandom_range(255, 256));
      end
      len = win_len + $urandom_range(1, 30);
      if ($urandom_range(9) == 0) len = $urandom_range(1, win_len);
      close_stream = ($urandom_range(4) != 0);
      mode   = $urandom_range(2);
      base   = ($urandom_range(3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 90);
      spread = $urandom_range(0, 20);
      for (int k = 0; k < len; k++) begin
        case (mode)
          0: begin
            v = $urandom_range(0, 255);
          end
          1: begin
            // Values near a baseline with occasional spikes.
            v = base + $urandom_range(0, spread);
            if ($urandom_range(7) == 0) v = $urandom_range(0, 255);
          end
          default: begin
            // A handful of distinct values, extremes included.
            pick = $urandom_range(4);
            v = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 254 :
                (pick == 3) ? 255 : base;
          end
        endcase
        if (v > 255) v = 255;
        send_sample(v[smoa_pkg::SAMPLE_W-1:0], close_stream && (k == len - 1));
        sent++;
      end
    end
  endtask

  // Result receiver: random back-pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Compare each accepted result with the oldest pending one.
  always @(posedge clk) begin : check_results
    alert_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_alerts.size() == 0) begin
        note_mismatch("result with none pending", 32'd0, 32'd1);
      end else begin
        want = pending_alerts.pop_front();
        if (alert !== want.alert) note_mismatch("alert", want.alert, alert);
        if (window_full !== want.full) note_mismatch("window_full", want.full, window_full);
        if (doubled_median !== want.dbl) note_mismatch("doubled_median", want.dbl, doubled_median);
        if (alert_total !== want.total) note_mismatch("alert_total", want.total, alert_total);
        if (final_res !== want.fin) note_mismatch("final_res", want.fin, final_res);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sliding_median_outlier_alert_test: errors");
      $finish;
    end
  end

  initial begin
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid    <= 1'b0;
    sample      <= '0;
    last_sample <= 1'b0;
    out_ready   <= 1'b0;
    mismatches   = 0;
    snd_idle_pct = 30;
    rcv_idle_pct = 53;
    for (int i = 0; i < DEPTH; i++) begin
      ring_val[i] = '0;
    end
    win_len = 1;
    clear_stream();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_window();
    test_even_window();
    test_odd_window();
    test_deepest_window();
    test_random_streams(30, 53, 370);
    test_random_streams(53, 30, 370);
    test_random_streams(0, 0, 370);

    drain();
    if (mismatches == 0) begin
      $display("sliding_median_outlier_alert_test: clean");
    end else begin
      $display("sliding_median_outlier_alert_test: errors");
    end
    $finish;
  end

endmodule
